/* design/dmlc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmlc_pkg
// shared types, codes and helpers of the drive mode and launch controller
// ----------------------------------------------------------------------------
package dmlc_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] REG_BUTTON_FRAME_ID   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PRESS_CODE        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_RELEASE_CODE      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_LAUNCH_RPM_LOW    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_LAUNCH_RPM_HIGH   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_WARN_START_RPM    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_PROFILE_STAB_MODE = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_LAUNCH_ENABLE     = 3'd7;

   localparam logic [1:0] STAB_ON    = 2'd0;
   localparam logic [1:0] STAB_OFF   = 2'd1;
   localparam logic [1:0] STAB_TRACK = 2'd2;

   localparam logic [2:0] KIND_SPORT_ON   = 3'd0;
   localparam logic [2:0] KIND_SPORT_OFF  = 3'd1;
   localparam logic [2:0] KIND_MENU       = 3'd2;
   localparam logic [2:0] KIND_STAB_BASE  = 3'd3;
   localparam logic [2:0] KIND_FLASH      = 3'd6;
   localparam logic [2:0] KIND_LIGHTS_OFF = 3'd7;

   localparam logic [7:0] HOLD_LIMIT = 8'd10;
   localparam logic [7:0] HOLD_MAX   = 8'd255;

   typedef struct packed {
      logic [10:0] button_frame_id;
      logic [7:0]  press_code;
      logic [7:0]  release_code;
      logic [15:0] launch_rpm_low;
      logic [15:0] launch_rpm_high;
      logic [15:0] warn_start_rpm;
      logic [1:0]  profile_stability_mode;
      logic        launch_enable;
   } cfg_type;

   typedef struct packed {
      logic        mode;
      logic [10:0] frame_id;
      logic [7:0]  frame_byte;
      logic [15:0] engine_rpm;
      logic        clutch_down;
      logic        car_moving;
   } req_type;

   typedef struct packed {
      logic [1:0] count;
      logic [2:0] kind0;
      logic [2:0] kind1;
      logic       sport_active;
      logic [1:0] stability_status;
   } rsp_set_type;

   function automatic rsp_set_type emit_kind(rsp_set_type s, logic [2:0] kind);
      rsp_set_type r;
      r = s;
      if (s.count == 2'd0) begin
         r.kind0 = kind;
         r.count = 2'd1;
      end else begin
         r.kind1 = kind;
         r.count = 2'd2;
      end
      return r;
   endfunction

endpackage

/* design/dmlc_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmlc_cfg_regs
// configuration register file, written through the csr port
// ----------------------------------------------------------------------------
module dmlc_cfg_regs (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [dmlc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dmlc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output dmlc_pkg::cfg_type               cfg
);
   import dmlc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_BUTTON_FRAME_ID:   cfg_in.button_frame_id        = csr_wdata[10:0];
            REG_PRESS_CODE:        cfg_in.press_code             = csr_wdata[7:0];
            REG_RELEASE_CODE:      cfg_in.release_code           = csr_wdata[7:0];
            REG_LAUNCH_RPM_LOW:    cfg_in.launch_rpm_low         = csr_wdata;
            REG_LAUNCH_RPM_HIGH:   cfg_in.launch_rpm_high        = csr_wdata;
            REG_WARN_START_RPM:    cfg_in.warn_start_rpm         = csr_wdata;
            REG_PROFILE_STAB_MODE: cfg_in.profile_stability_mode = csr_wdata[1:0];
            REG_LAUNCH_ENABLE:     cfg_in.launch_enable          = csr_wdata[0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* design/dmlc_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmlc_core
// button and launch state, and the result words of one registered item
// ----------------------------------------------------------------------------
module dmlc_core (
   input  logic                  clock,
   input  logic                  reset,
   input  dmlc_pkg::cfg_type     cfg,
   input  dmlc_pkg::req_type     req,
   input  logic                  step,
   output dmlc_pkg::rsp_set_type rsp_set
);
   import dmlc_pkg::*;

   logic       button_held_ff, button_held_in;
   logic [7:0] hold_count_ff, hold_count_in;
   logic       sport_on_ff, sport_on_in;
   logic [1:0] stability_now_ff, stability_now_in;
   logic       launch_armed_ff, launch_armed_in;

   always_comb begin
      rsp_set_type s;
      logic        profile_ok;
      logic        in_window;
      s                = '0;
      profile_ok       = (cfg.profile_stability_mode <= STAB_TRACK);
      in_window        = (cfg.launch_rpm_low <= req.engine_rpm) &&
                         (req.engine_rpm <= cfg.launch_rpm_high);
      button_held_in   = button_held_ff;
      hold_count_in    = hold_count_ff;
      sport_on_in      = sport_on_ff;
      stability_now_in = stability_now_ff;
      launch_armed_in  = launch_armed_ff;

      if (!req.mode) begin
         if (req.frame_id == cfg.button_frame_id) begin
            if (req.frame_byte == cfg.press_code && !button_held_ff) begin
               button_held_in = 1'b1;
               hold_count_in  = 8'd0;
            end else if (req.frame_byte == cfg.release_code && button_held_ff) begin
               button_held_in = 1'b0;
               hold_count_in  = 8'd0;
               if (hold_count_ff < HOLD_LIMIT) begin
                  sport_on_in = !sport_on_ff;
                  if (!sport_on_ff) begin
                     s = emit_kind(s, KIND_SPORT_ON);
                     if (profile_ok && cfg.profile_stability_mode != stability_now_ff) begin
                        stability_now_in = cfg.profile_stability_mode;
                        s = emit_kind(s, KIND_STAB_BASE + {1'b0, cfg.profile_stability_mode});
                     end
                  end else begin
                     s = emit_kind(s, KIND_SPORT_OFF);
                     if (stability_now_ff != STAB_ON) begin
                        stability_now_in = STAB_ON;
                        s = emit_kind(s, KIND_STAB_BASE);
                     end
                  end
               end
            end
            if (button_held_in) begin
               if (hold_count_in < HOLD_MAX) begin
                  hold_count_in = hold_count_in + 8'd1;
               end
               if (hold_count_in > HOLD_LIMIT) begin
                  s = emit_kind(s, KIND_MENU);
               end
            end
         end
      end else if (cfg.launch_enable) begin
         if (in_window) begin
            if (req.clutch_down && !req.car_moving) begin
               launch_armed_in = 1'b1;
               s = emit_kind(s, KIND_FLASH);
               if (stability_now_ff != STAB_TRACK) begin
                  stability_now_in = STAB_TRACK;
                  s = emit_kind(s, KIND_STAB_BASE + {1'b0, STAB_TRACK});
               end
            end
         end else if (launch_armed_ff) begin
            launch_armed_in = 1'b0;
            if (req.engine_rpm < cfg.warn_start_rpm) begin
               s = emit_kind(s, KIND_LIGHTS_OFF);
            end
            if (profile_ok && stability_now_ff != cfg.profile_stability_mode) begin
               stability_now_in = cfg.profile_stability_mode;
               s = emit_kind(s, KIND_STAB_BASE + {1'b0, cfg.profile_stability_mode});
            end
         end
      end

      s.sport_active     = sport_on_in;
      s.stability_status = stability_now_in;
      rsp_set            = s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         button_held_ff   <= 1'b0;
         hold_count_ff    <= 8'd0;
         sport_on_ff      <= 1'b0;
         stability_now_ff <= STAB_ON;
         launch_armed_ff  <= 1'b0;
      end else if (step) begin
         button_held_ff   <= button_held_in;
         hold_count_ff    <= hold_count_in;
         sport_on_ff      <= sport_on_in;
         stability_now_ff <= stability_now_in;
         launch_armed_ff  <= launch_armed_in;
      end
   end

endmodule

/* design/dmlc_rsp_buf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmlc_rsp_buf
// result register holding the up to two words of one item
// ----------------------------------------------------------------------------
module dmlc_rsp_buf (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               load,
   input  dmlc_pkg::rsp_set_type              rsp_set,
   output logic                               free,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [dmlc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [2:0]                         rsp_tuser,
   output logic                               rsp_tlast
);
   import dmlc_pkg::*;

   rsp_set_type buf_ff, buf_in;
   logic        take;

   assign take = rsp_tvalid && rsp_tready;
   assign free = (buf_ff.count == 2'd0) || (buf_ff.count == 2'd1 && rsp_tready);

   always_comb begin
      buf_in = buf_ff;
      if (load) begin
         buf_in = rsp_set;
      end else if (take) begin
         if (buf_ff.count == 2'd2) begin
            buf_in.kind0 = buf_ff.kind1;
            buf_in.count = 2'd1;
         end else begin
            buf_in.count = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff.count <= 2'd0;
      end else begin
         buf_ff.count <= buf_in.count;
      end
      buf_ff.kind0            <= buf_in.kind0;
      buf_ff.kind1            <= buf_in.kind1;
      buf_ff.sport_active     <= buf_in.sport_active;
      buf_ff.stability_status <= buf_in.stability_status;
   end

   assign rsp_tvalid = (buf_ff.count != 2'd0);
   assign rsp_tlast  = (buf_ff.count == 2'd1);
   assign rsp_tuser  = buf_ff.kind0;
   assign rsp_tdata  = {{(RSP_DATA_W-3){1'b0}}, buf_ff.stability_status,
                        buf_ff.sport_active};

endmodule

/* design/drive_mode_launch_controller_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drive_mode_launch_controller_top
// button press/hold tracking, sport toggle, menu request and launch control
// ----------------------------------------------------------------------------
// channel  dir  word
// req_     in   tuser: mode; tdata: frame_id, frame_byte, engine_rpm,
//                clutch_down, car_moving
// rsp_     out  tuser: message_kind; tdata: sport_active, stability_status;
//                tlast: last word of an item
// csr_     in   write enable, register index, write data
//
// an item is taken each cycle when it gives at most one word and rsp_ is
// ready; an item of two words holds back the next until its first word is
// taken; rsp_ moves one word a cycle while rsp_tready is high; items pass
// the input stage, then the result register, also those with no words
// synchronous reset clears state, registers and both stages
// a stalled rsp_ holds the result register and backs up into the input stage
// ----------------------------------------------------------------------------
module drive_mode_launch_controller_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // frame_id, frame_byte, engine_rpm, clutch_down, car_moving
   input  logic [dmlc_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [0:0]                         req_tuser,  // mode
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [dmlc_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // sport_active, stability_status
   output logic [2:0]                         rsp_tuser,  // message_kind
   output logic                               rsp_tlast,
   input  logic                               csr_we,
   input  logic [dmlc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [dmlc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import dmlc_pkg::*;

   cfg_type     cfg;
   req_type     req_ff, req_in;
   logic        req_valid_ff, req_valid_in;
   rsp_set_type rsp_set;
   logic        buf_free;
   logic        advance;

   assign advance    = req_valid_ff && buf_free;
   assign req_tready = !req_valid_ff || advance;

   always_comb begin
      req_in.mode        = req_tuser[0];
      req_in.frame_id    = req_tdata[10:0];
      req_in.frame_byte  = req_tdata[18:11];
      req_in.engine_rpm  = req_tdata[34:19];
      req_in.clutch_down = req_tdata[35];
      req_in.car_moving  = req_tdata[36];
      req_valid_in       = req_valid_ff;
      if (req_tready) begin
         req_valid_in = req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
      if (req_tready && req_tvalid) begin
         req_ff <= req_in;
      end
   end

   dmlc_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dmlc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req     (req_ff),
      .step    (advance),
      .rsp_set (rsp_set)
   );

   dmlc_rsp_buf u_rsp (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .rsp_set    (rsp_set),
      .free       (buf_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
